// ----- src/fpg_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register codes, controller state type, multiplier command and sine math.
package fpg_pkg;

  // Sizing of the serial multiply-accumulate datapath
  localparam int ACC_W    = 52;
  localparam int MPLIER_W = 32;
  localparam int DIGIT_W  = 4;

  // Sine table
  localparam int DEFAULT_SINE_DEPTH = 1024;
  localparam int SINE_W             = 15;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_KP    = 3'd0;
  localparam logic [2:0] REG_KI    = 3'd1;
  localparam logic [2:0] REG_KD    = 3'd2;
  localparam logic [2:0] REG_KG    = 3'd3;
  localparam logic [2:0] REG_ALPHA = 3'd4;
  localparam logic [2:0] REG_LIMIT = 3'd5;

  // Arithmetic constants
  localparam logic [16:0]         ALPHA_ONE       = 17'd65536;
  localparam logic [MPLIER_W-1:0] INT_STEP_Q32    = 32'd8589935;
  localparam logic [MPLIER_W-1:0] TWO_OVER_PI_Q30 = 32'd683565276;

  localparam logic signed [ACC_W-1:0] FILT_ROUND = ACC_W'(1) << 15;
  localparam logic signed [ACC_W-1:0] INT_ROUND  = ACC_W'(1) << 23;
  localparam logic signed [ACC_W-1:0] IDX_ROUND  = ACC_W'(1) << 29;
  localparam logic signed [ACC_W-1:0] TQ_ROUND   = ACC_W'(1) << 19;

  typedef longint unsigned u64_t;

  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t ONE_Q30     = 64'd1073741824;

  // Controller sequence: one multiply per state from S_FILT to S_TQG
  typedef enum logic [3:0] {
    S_IDLE,
    S_FILT,
    S_INTG,
    S_SINP,
    S_SIDX,
    S_TQP,
    S_TQI,
    S_TQD,
    S_TQG,
    S_EMIT
  } state_t;

  // Command to the serial multiply-accumulate unit
  typedef struct packed {
    logic                      start;
    logic                      keep;
    logic signed [ACC_W-1:0]   init;
    logic signed [ACC_W-1:0]   mcand;
    logic [MPLIER_W-1:0]       mplier;
  } mac_cmd_t;

  // Quarter-wave sine entry in Q1.15 for a Q30 fraction of a quarter turn
  function automatic logic [SINE_W-1:0] sine_entry(input u64_t u);
    u64_t t;
    u64_t t2;
    u64_t r;
    u64_t s;
    u64_t q;
    t  = (u * HALF_PI_Q30) >> 30;
    t2 = (t * t) >> 30;
    r  = ONE_Q30 - t2 / 72;
    r  = ONE_Q30 - ((t2 * r) >> 30) / 42;
    r  = ONE_Q30 - ((t2 * r) >> 30) / 20;
    r  = ONE_Q30 - ((t2 * r) >> 30) / 6;
    s  = (t * r) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return SINE_W'(q);
  endfunction

endpackage

// ----- src/fpg_serial_mac.sv -----
`timescale 1ns / 1ps
// Digit-serial multiply-accumulate unit: one 4-bit multiplier digit per cycle.
module fpg_serial_mac import fpg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_cmd_t                cmd,
  output logic signed [ACC_W-1:0] acc,
  output logic                    done
);

  logic signed [ACC_W-1:0]       mcand_sh;
  logic [MPLIER_W-1:0]           mplier;
  logic signed [ACC_W+DIGIT_W:0] partial;

  // Form the partial product of the lowest multiplier digit
  always_comb begin
    partial = mcand_sh * $signed({1'b0, mplier[DIGIT_W-1:0]});
  end

  // Finished once no multiplier digits remain
  assign done = (mplier == '0);

  // Load a command, else shift one digit through
  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (cmd.start) begin
      mplier   <= cmd.mplier;
      mcand_sh <= cmd.mcand;
      if (!cmd.keep) begin
        acc <= cmd.init;
      end
    end else if (!done) begin
      acc      <= acc + $signed(partial[ACC_W-1:0]);
      mcand_sh <= mcand_sh <<< DIGIT_W;
      mplier   <= mplier >> DIGIT_W;
    end
  end

endmodule

// ----- src/fpg_sine_rom.sv -----
`timescale 1ns / 1ps
// Quarter-wave sine table, built at elaboration, with a registered read port.
module fpg_sine_rom import fpg_pkg::*; #(
  parameter  int SINE_TABLE_DEPTH = DEFAULT_SINE_DEPTH,
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  addr,
  output logic [SINE_W-1:0] data
);

  logic [SINE_W-1:0] rom [SINE_TABLE_DEPTH + 1];

  // Fill each entry from the series evaluation
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_entry
    localparam u64_t U = (u64_t'(k) << 30) / SINE_TABLE_DEPTH;
    assign rom[k] = sine_entry(U);
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= rom[addr];
    end
  end

endmodule

// ----- src/filtered_pid_gravity_ff.sv -----
`timescale 1ns / 1ps
// Joint PID controller with filtered error and gravity feedforward, top level.
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+-------------------------------------------
//   sample    | sample_valid / sample_ready   | angle_measured, angle_reference, first_step
//   result    | result_valid / result_ready   | torque_command, filtered_error,
//             |                               | integral_value, derivative_value
//   config    | psel penable pwrite pready    | paddr, pwdata, prdata
//
// A request runs through the sequence states from its acceptance to result_valid; all
// eight multiplies go in turn through one 4-bit digit-serial multiply-accumulate unit,
// so the time a request takes follows how many 4-bit digits alpha and each gain span.
// The controller passes through its idle state before the next request is taken.
// Synchronous reset clears gains, sets alpha to one and the torque limit to full scale,
// and zeroes the stored error and integral. A result waits in the output register while
// the next request is accepted; a stalled result only holds back the following one.
module filtered_pid_gravity_ff import fpg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = DEFAULT_SINE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic signed [15:0]      angle_measured,
  input  logic signed [15:0]      angle_reference,
  input  logic                    first_step,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  output logic signed [15:0]      torque_command,
  output logic signed [15:0]      filtered_error,
  output logic signed [31:0]      integral_value,
  output logic signed [31:0]      derivative_value,
  output logic                    result_valid,
  input  logic                    result_ready
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

  localparam logic signed [31:0] INT_MAX32 = 32'sh7fffffff;
  localparam logic signed [31:0] INT_MIN32 = 32'sh80000000;

  // Configuration registers
  logic [15:0] gain_proportional;
  logic [15:0] gain_integral;
  logic [15:0] gain_derivative;
  logic [15:0] gain_gravity;
  logic [16:0] filter_alpha;
  logic [14:0] torque_limit;

  // Controller state
  logic signed [15:0] previous_error;
  logic signed [31:0] integral_accumulator;

  // Working registers
  state_t             state;
  state_t             state_next;
  logic signed [15:0] meas_q;
  logic               first_q;
  logic signed [15:0] e_q;
  logic signed [31:0] integ_q;
  logic signed [31:0] deriv_q;
  logic [1:0]         quad_q;

  // Datapath wires
  mac_cmd_t                cmd;
  logic signed [ACC_W-1:0] acc;
  logic                    mac_done;
  logic                    accept;
  logic                    ld_e;
  logic                    ld_integ;
  logic                    ld_quad;
  logic                    rom_rd;
  logic                    emit;
  logic                    emit_ok;
  logic                    cfg_wr;
  logic [16:0]             a_eff;
  logic signed [16:0]      raw;
  logic signed [17:0]      diff;
  logic signed [ACC_W-1:0] filt_init;
  logic signed [ACC_W-17:0] filt_full;
  logic signed [15:0]      e_sat;
  logic signed [16:0]      inc;
  logic signed [32:0]      integ_sum;
  logic signed [31:0]      integ_sat;
  logic signed [15:0]      prev_eff;
  logic signed [16:0]      e_diff;
  logic signed [31:0]      deriv_calc;
  logic [15:0]             mag;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        rom_addr;
  logic [SINE_W-1:0]       rom_data;
  logic signed [15:0]      sin_pos;
  logic signed [15:0]      sin_val;
  logic signed [31:0]      tq_full;
  logic signed [31:0]      lim;
  logic signed [31:0]      neg_lim;
  logic signed [15:0]      tq_clamp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = sample_valid && sample_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_proportional <= '0;
      gain_integral     <= '0;
      gain_derivative   <= '0;
      gain_gravity      <= '0;
      filter_alpha      <= ALPHA_ONE;
      torque_limit      <= 15'h7fff;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_KP:    gain_proportional <= pwdata[15:0];
        REG_KI:    gain_integral     <= pwdata[15:0];
        REG_KD:    gain_derivative   <= pwdata[15:0];
        REG_KG:    gain_gravity      <= pwdata[15:0];
        REG_ALPHA: filter_alpha      <= pwdata[16:0];
        REG_LIMIT: torque_limit      <= pwdata[14:0];
        default:   ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (paddr[4:2])
      REG_KP:    prdata = CFG_DATA_W'(gain_proportional);
      REG_KI:    prdata = CFG_DATA_W'(gain_integral);
      REG_KD:    prdata = CFG_DATA_W'(gain_derivative);
      REG_KG:    prdata = CFG_DATA_W'(gain_gravity);
      REG_ALPHA: prdata = CFG_DATA_W'(filter_alpha);
      REG_LIMIT: prdata = CFG_DATA_W'(torque_limit);
      default:   prdata = '0;
    endcase
  end

  // Filter operands: prev*65536 + (raw - prev)*alpha, with rounding
  always_comb begin
    a_eff     = (filter_alpha > ALPHA_ONE) ? ALPHA_ONE : filter_alpha;
    raw       = 17'(angle_reference) - 17'(angle_measured);
    diff      = 18'(raw) - 18'(previous_error);
    filt_init = (ACC_W'(previous_error) <<< 16) + FILT_ROUND;
  end

  // Scale and saturate the filtered error
  always_comb begin
    filt_full = $signed(acc[ACC_W-1:16]);
    if (filt_full > 32767) begin
      e_sat = 16'sh7fff;
    end else if (filt_full < -32768) begin
      e_sat = 16'sh8000;
    end else begin
      e_sat = filt_full[15:0];
    end
  end

  // Integral step and saturating accumulate; derivative times 500
  always_comb begin
    inc       = $signed(acc[40:24]);
    integ_sum = 33'(integral_accumulator) + 33'(inc);
    if (integ_sum[32] != integ_sum[31]) begin
      integ_sat = integ_sum[32] ? INT_MIN32 : INT_MAX32;
    end else begin
      integ_sat = integ_sum[31:0];
    end
    prev_eff   = first_q ? e_q : previous_error;
    e_diff     = 17'(e_q) - 17'(prev_eff);
    deriv_calc = 32'(e_diff) * 32'sd500;
  end

  // Sine lookup: magnitude, table index with mirroring, sign
  always_comb begin
    mag      = meas_q[15] ? (~meas_q + 16'd1) : meas_q;
    idx      = acc[30 +: IDX_W];
    rom_addr = quad_q[0] ? (IDX_W'(SINE_TABLE_DEPTH) - idx) : idx;
    sin_pos  = {1'b0, rom_data};
    sin_val  = (quad_q[1] ^ meas_q[15]) ? -sin_pos : sin_pos;
  end

  // Round the torque sum and clamp to the limit
  always_comb begin
    tq_full = $signed(acc[ACC_W-1:20]);
    lim     = $signed({17'd0, torque_limit});
    neg_lim = -lim;
    if (tq_full > lim) begin
      tq_clamp = lim[15:0];
    end else if (tq_full < neg_lim) begin
      tq_clamp = neg_lim[15:0];
    end else begin
      tq_clamp = tq_full[15:0];
    end
  end

  assign emit_ok = !result_valid || result_ready;

  // Advance the sequence
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (sample_valid)  state_next = S_FILT;
      S_FILT: if (mac_done)      state_next = S_INTG;
      S_INTG: if (mac_done)      state_next = S_SINP;
      S_SINP: if (mac_done)      state_next = S_SIDX;
      S_SIDX: if (mac_done)      state_next = S_TQP;
      S_TQP:  if (mac_done)      state_next = S_TQI;
      S_TQI:  if (mac_done)      state_next = S_TQD;
      S_TQD:  if (mac_done)      state_next = S_TQG;
      S_TQG:  if (mac_done)      state_next = S_EMIT;
      S_EMIT: if (emit_ok)       state_next = S_IDLE;
      default:                   state_next = S_IDLE;
    endcase
  end

  // Drive multiplier commands and load enables
  always_comb begin
    cmd          = '0;
    sample_ready = 1'b0;
    ld_e         = 1'b0;
    ld_integ     = 1'b0;
    ld_quad      = 1'b0;
    rom_rd       = 1'b0;
    emit         = 1'b0;
    case (state)
      S_IDLE: begin
        sample_ready = !rst;
        if (sample_valid) begin
          cmd.start  = 1'b1;
          cmd.init   = filt_init;
          cmd.mcand  = ACC_W'(diff);
          cmd.mplier = MPLIER_W'(a_eff);
        end
      end
      S_FILT: begin
        if (mac_done) begin
          ld_e       = 1'b1;
          cmd.start  = 1'b1;
          cmd.init   = INT_ROUND;
          cmd.mcand  = ACC_W'(e_sat);
          cmd.mplier = INT_STEP_Q32;
        end
      end
      S_INTG: begin
        if (mac_done) begin
          ld_integ   = 1'b1;
          cmd.start  = 1'b1;
          cmd.mcand  = ACC_W'(mag);
          cmd.mplier = TWO_OVER_PI_Q30;
        end
      end
      S_SINP: begin
        if (mac_done) begin
          ld_quad    = 1'b1;
          cmd.start  = 1'b1;
          cmd.init   = IDX_ROUND;
          cmd.mcand  = ACC_W'(acc[41:12]);
          cmd.mplier = MPLIER_W'(SINE_TABLE_DEPTH);
        end
      end
      S_SIDX: begin
        if (mac_done) begin
          rom_rd     = 1'b1;
          cmd.start  = 1'b1;
          cmd.init   = TQ_ROUND;
          cmd.mcand  = ACC_W'(e_q) <<< 8;
          cmd.mplier = MPLIER_W'(gain_proportional);
        end
      end
      S_TQP: begin
        if (mac_done) begin
          cmd.start  = 1'b1;
          cmd.keep   = 1'b1;
          cmd.mcand  = ACC_W'(integ_q);
          cmd.mplier = MPLIER_W'(gain_integral);
        end
      end
      S_TQI: begin
        if (mac_done) begin
          cmd.start  = 1'b1;
          cmd.keep   = 1'b1;
          cmd.mcand  = ACC_W'(deriv_q) <<< 8;
          cmd.mplier = MPLIER_W'(gain_derivative);
        end
      end
      S_TQD: begin
        if (mac_done) begin
          cmd.start  = 1'b1;
          cmd.keep   = 1'b1;
          cmd.mcand  = ACC_W'(sin_val) <<< 5;
          cmd.mplier = MPLIER_W'(gain_gravity);
        end
      end
      S_TQG: ;
      S_EMIT: emit = emit_ok;
      default: ;
    endcase
  end

  // Hold the sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the request and intermediate values
  always_ff @(posedge clk) begin
    if (accept) begin
      meas_q  <= angle_measured;
      first_q <= first_step;
    end
    if (ld_e) begin
      e_q <= e_sat;
    end
    if (ld_integ) begin
      integ_q <= integ_sat;
      deriv_q <= deriv_calc;
    end
    if (ld_quad) begin
      quad_q <= acc[43:42];
    end
  end

  // Update controller state when the result is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error       <= '0;
      integral_accumulator <= '0;
    end else if (emit) begin
      previous_error       <= e_q;
      integral_accumulator <= integ_q;
    end
  end

  // Output register: load on issue, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      torque_command   <= tq_clamp;
      filtered_error   <= e_q;
      integral_value   <= integ_q;
      derivative_value <= deriv_q;
    end
  end

  fpg_serial_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .acc  (acc),
    .done (mac_done)
  );

  fpg_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk   (clk),
    .rd_en (rom_rd),
    .addr  (rom_addr),
    .data  (rom_data)
  );

endmodule

// ----- src/fpg_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the controller and the bind that attaches them.
module fpg_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  first_step,
  input logic                  sample_valid,
  input logic                  sample_ready,
  input logic signed [15:0]    torque_command,
  input logic signed [31:0]    integral_value,
  input logic signed [31:0]    derivative_value,
  input logic                  result_valid,
  input logic                  result_ready
);

  logic accept;
  logic held_q;
  logic res_new;
  logic owed;
  logic first_q;

  assign accept  = sample_valid && sample_ready;
  assign res_new = result_valid && !held_q;

  // Track an accepted request whose result has not yet appeared
  always_ff @(posedge clk) begin
    if (rst) begin
      held_q  <= 1'b0;
      owed    <= 1'b0;
      first_q <= 1'b0;
    end else begin
      held_q <= result_valid && !result_ready;
      if (accept) begin
        owed    <= 1'b1;
        first_q <= first_step;
      end else if (res_new) begin
        owed <= 1'b0;
      end
    end
  end

  // One request in flight at a time
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!owed || res_new))
    else $error("request accepted while an earlier one is still in flight");

  // Every result answers a request
  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    res_new |-> owed)
    else $error("result issued with no request outstanding");

  // A first step yields a zero derivative
  a_first_deriv: assert property (@(posedge clk) disable iff (rst)
    (res_new && first_q) |-> (derivative_value == 32'sd0))
    else $error("nonzero derivative on first step");

  // The symmetric clamp never reaches the most negative code
  a_torque_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (torque_command != 16'sh8000))
    else $error("torque outside symmetric limit");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(torque_command) && $stable(integral_value)))
    else $error("stalled result changed");

endmodule

bind filtered_pid_gravity_ff fpg_checker u_checker (.*);

// ----- bench/filtered_pid_gravity_ff_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the filtered PID controller with gravity feedforward.
module filtered_pid_gravity_ff_tb;
  import fpg_pkg::*;

  localparam int SINE_DEPTH      = DEFAULT_SINE_DEPTH;
  localparam int CYCLE_LIMIT     = 30000000;
  localparam int SETTLE_CYCLES   = 64;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SWEEP_ITEMS     = 40;
  localparam int UNWIND_ITEMS    = 20;

  localparam longint UNITY_ALPHA = 65536;
  localparam longint INTEG_STEP  = 8589935;
  localparam longint DIFF_SCALE  = 500;
  localparam longint INTEG_MAX   = 64'sh7FFF_FFFF;
  localparam longint INTEG_MIN   = -64'sh8000_0000;
  localparam longint ERR_MAX     = 32767;
  localparam longint ERR_MIN     = -32768;

  localparam longint unsigned Q30_ONE         = 64'd1073741824;
  localparam longint unsigned Q30_HALF_PI     = 64'd1686629713;
  localparam longint unsigned Q30_TWO_OVER_PI = 64'd683565276;

  typedef struct {
    logic signed [15:0] measured;
    logic signed [15:0] wanted;
    logic               first;
  } sample_t;

  typedef struct {
    logic signed [15:0] torque;
    logic signed [15:0] error;
    logic signed [31:0] integral;
    logic signed [31:0] slope;
  } control_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic signed [15:0]    angle_measured = '0;
  logic signed [15:0]    angle_reference = '0;
  logic                  first_step = 1'b0;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  logic signed [15:0]    torque_command;
  logic signed [15:0]    filtered_error;
  logic signed [31:0]    integral_value;
  logic signed [31:0]    derivative_value;
  logic                  result_valid;
  logic                  result_ready = 1'b0;

  // Controller copy: registers, stored error, integral, sine table
  longint gain_p = 0;
  longint gain_i = 0;
  longint gain_d = 0;
  longint gain_g = 0;
  longint alpha_reg = UNITY_ALPHA;
  longint limit_reg = 32767;
  longint err_prev = 0;
  longint integ_acc = 0;
  longint quarter_sine [0:SINE_DEPTH];

  sample_t      sample_queue[$];
  control_out_t expected_results[$];

  int samples_sent = 0;
  int samples_taken = 0;
  int results_seen = 0;
  int results_paced = 0;
  int send_gap = 0;
  int recv_stall = 0;
  int mismatch_count = 0;
  int settings_applied = 0;
  int cycle_count = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit fast_mode = 1'b0;

  filtered_pid_gravity_ff dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .angle_measured   (angle_measured),
    .angle_reference  (angle_reference),
    .first_step       (first_step),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .torque_command   (torque_command),
    .filtered_error   (filtered_error),
    .integral_value   (integral_value),
    .derivative_value (derivative_value),
    .result_valid     (result_valid),
    .result_ready     (result_ready)
  );

  always #5 clk = ~clk;

  // Fill the quarter-wave table: Taylor series in Q2.30, rounded to Q1.15
  function automatic void build_quarter_sine();
    longint unsigned u, t, t2, r, s, q;
    int k;
    for (k = 0; k <= SINE_DEPTH; k++) begin
      u  = (longint'(k) << 30) / SINE_DEPTH;
      t  = (u * Q30_HALF_PI) >> 30;
      t2 = (t * t) >> 30;
      r  = Q30_ONE - t2 / 72;
      r  = Q30_ONE - ((t2 * r) >> 30) / 42;
      r  = Q30_ONE - ((t2 * r) >> 30) / 20;
      r  = Q30_ONE - ((t2 * r) >> 30) / 6;
      s  = (t * r) >> 30;
      q  = (s + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      quarter_sine[k] = longint'(q);
    end
  endfunction

  // Sine of a Q4.12 angle in Q1.15 by quadrant folding
  function automatic longint gravity_sine(input logic signed [15:0] angle);
    longint          a;
    longint          v;
    longint unsigned mag, p, quad, frac, idx;
    a    = longint'(angle);
    mag  = (a < 0) ? -a : a;
    p    = (mag * Q30_TWO_OVER_PI) >> 12;
    quad = (p >> 30) & 64'd3;
    frac = p & (Q30_ONE - 1);
    idx  = (frac * SINE_DEPTH + (64'd1 << 29)) >> 30;
    if (idx > SINE_DEPTH) begin
      idx = SINE_DEPTH;
    end
    if (quad[0]) begin
      idx = SINE_DEPTH - idx;
    end
    v = quarter_sine[idx];
    if (quad[1]) begin
      v = -v;
    end
    if (a < 0) begin
      v = -v;
    end
    return v;
  endfunction

  // Advance the controller copy by one sample and return the expected result
  function automatic control_out_t control_step(input sample_t s);
    control_out_t res;
    longint meas, wanted, raw, alpha, e, inc, integ, deriv, sum, torque;
    meas   = longint'(s.measured);
    wanted = longint'(s.wanted);
    alpha  = (alpha_reg > UNITY_ALPHA) ? UNITY_ALPHA : alpha_reg;
    raw    = wanted - meas;

    // low-pass on the tracking error
    e = (err_prev * (UNITY_ALPHA - alpha) + raw * alpha + 32768) >>> 16;
    if (e > ERR_MAX) begin
      e = ERR_MAX;
    end else if (e < ERR_MIN) begin
      e = ERR_MIN;
    end
    if (s.first) begin
      err_prev = e;
    end

    // saturating integral and scaled difference
    inc   = (e * INTEG_STEP + (longint'(1) <<< 23)) >>> 24;
    integ = integ_acc + inc;
    if (integ > INTEG_MAX) begin
      integ = INTEG_MAX;
    end else if (integ < INTEG_MIN) begin
      integ = INTEG_MIN;
    end
    deriv = (e - err_prev) * DIFF_SCALE;

    // sum at Q.28, round to Q8.8, clamp
    sum = gain_p * e * 256 + gain_i * integ + gain_d * deriv * 256
        + gain_g * gravity_sine(s.measured) * 32;
    torque = (sum + (longint'(1) <<< 19)) >>> 20;
    if (torque > limit_reg) begin
      torque = limit_reg;
    end else if (torque < -limit_reg) begin
      torque = -limit_reg;
    end

    err_prev  = e;
    integ_acc = integ;

    res.torque   = torque[15:0];
    res.error    = e[15:0];
    res.integral = integ[31:0];
    res.slope    = deriv[31:0];
    return res;
  endfunction

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
    end
  endtask

  function automatic int draw_wait(input bit burst);
    if (fast_mode || burst) begin
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Present requests at the falling edge, hold each until accepted
  always @(negedge clk) begin : drive_samples
    sample_t next;
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || samples_taken == samples_sent) begin
      if (send_gap > 0) begin
        send_gap--;
        sample_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        next = sample_queue.pop_front();
        angle_measured  <= next.measured;
        angle_reference <= next.wanted;
        first_step      <= next.first;
        sample_valid    <= 1'b1;
        samples_sent++;
        send_gap = draw_wait(send_burst);
        if ($urandom_range(0, 39) == 0) begin
          send_burst = !send_burst;
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Stall the result side for a drawn number of cycles per result
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (results_seen != results_paced) begin
        results_paced = results_seen;
        recv_stall = draw_wait(recv_burst);
        if ($urandom_range(0, 39) == 0) begin
          recv_burst = !recv_burst;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin : watch_ports
    sample_t      seen;
    control_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result with no request outstanding: torque %0d", torque_command);
        end
      end else begin
        want = expected_results.pop_front();
        check_field("torque_command", longint'(want.torque), longint'(torque_command));
        check_field("filtered_error", longint'(want.error), longint'(filtered_error));
        check_field("integral_value", longint'(want.integral), longint'(integral_value));
        check_field("derivative_value", longint'(want.slope),
                    longint'(derivative_value));
      end
    end
    if (!rst && sample_valid && sample_ready) begin
      seen.measured = angle_measured;
      seen.wanted   = angle_reference;
      seen.first    = first_step;
      expected_results.push_back(control_step(seen));
      samples_taken++;
    end
  end

  // Write one register, then read it back
  task automatic write_reg(input logic [2:0] index, input longint value);
    logic [CFG_DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("register readback", value, longint'(got));
  endtask

  task automatic apply_setting(input longint kp, input longint ki, input longint kd,
                               input longint kg, input longint alpha, input longint lim);
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_KG, kg);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_LIMIT, lim);
    gain_p    = kp;
    gain_i    = ki;
    gain_d    = kd;
    gain_g    = kg;
    alpha_reg = alpha;
    limit_reg = lim;
    settings_applied++;
  endtask

  // Hold off until every request is out and every result is back
  task automatic drain();
    while (sample_queue.size() != 0 || sample_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_sample(input int meas, input int wanted, input bit first);
    sample_t s;
    s.measured = 16'(meas);
    s.wanted   = 16'(wanted);
    s.first    = first;
    sample_queue.push_back(s);
  endtask

  function automatic longint pick_gain();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return longint'($urandom_range(0, 255));
      2:       return longint'($urandom_range(0, 4095));
      default: return longint'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic longint pick_alpha();
    case ($urandom_range(0, 4))
      0:       return UNITY_ALPHA;
      1:       return 0;
      2:       return longint'($urandom_range(0, 131071));
      default: return longint'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic longint pick_limit();
    case ($urandom_range(0, 3))
      0:       return 32767;
      1:       return longint'($urandom_range(0, 32767));
      2:       return longint'($urandom_range(0, 2047));
      default: return 32767;
    endcase
  endfunction

  function automatic int extreme_angle();
    case ($urandom_range(0, 3))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  // Mostly close tracking, some full-range and extreme angles
  function automatic sample_t random_sample();
    sample_t s;
    int      m;
    int      w;
    case ($urandom_range(0, 9))
      0: begin
        m = $urandom_range(0, 65535) - 32768;
        w = $urandom_range(0, 65535) - 32768;
      end
      1: begin
        m = extreme_angle();
        w = extreme_angle();
      end
      default: begin
        m = $urandom_range(0, 65535) - 32768;
        w = m + $urandom_range(0, 4000) - 2000;
        if (w > 32767) begin
          w = 32767;
        end else if (w < -32768) begin
          w = -32768;
        end
      end
    endcase
    s.measured = 16'(m);
    s.wanted   = 16'(w);
    s.first    = ($urandom_range(0, 29) == 0);
    return s;
  endfunction

  initial begin
    int phase;
    int n;
    build_quarter_sine();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: zero gains, unity alpha, full-scale limit
    add_sample(0, 1000, 1'b1);
    add_sample(-32768, 32767, 1'b0);
    add_sample(500, -500, 1'b0);
    drain();

    // moderate gains, real filtering: field extremes and sine quadrants
    apply_setting('h0180, 'h0040, 'h0004, 'h0200, 40000, 20000);
    add_sample(0, 1000, 1'b1);
    add_sample(-32768, 32767, 1'b0);
    add_sample(32767, -32768, 1'b0);
    add_sample(32767, 32767, 1'b0);
    add_sample(-32768, -32768, 1'b0);
    add_sample(100, -5000, 1'b1);
    add_sample(3217, 3217, 1'b0);
    add_sample(6434, 6434, 1'b0);
    add_sample(12868, 12868, 1'b0);
    add_sample(19302, 19302, 1'b0);
    add_sample(25736, 25736, 1'b0);
    add_sample(-6434, -6000, 1'b0);
    add_sample(-12868, 0, 1'b0);
    add_sample(0, 0, 1'b0);
    drain();

    // zero torque limit with alpha above unity and full gains
    apply_setting(65535, 65535, 65535, 65535, 131071, 0);
    add_sample(-32768, 32767, 1'b0);
    add_sample(32767, -32768, 1'b1);
    add_sample(1, -1, 1'b0);
    add_sample(6434, 0, 1'b0);
    drain();

    // alpha zero: filter output stays on the stored error
    apply_setting(0, 0, 65535, 65535, 0, 32767);
    add_sample(-32768, 32767, 1'b0);
    add_sample(20000, -20000, 1'b1);
    add_sample(-20000, 0, 1'b0);
    drain();

    // random phases, first with gains and limit at their maximum and alpha at 1
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        apply_setting(65535, 65535, 65535, 65535, 1, 32767);
      end else if (phase == 1) begin
        apply_setting(0, 0, 0, 0, longint'($urandom_range(0, 65536)),
                      longint'($urandom_range(0, 32767)));
      end else begin
        apply_setting(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_alpha(),
                      pick_limit());
      end
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        sample_queue.push_back(random_sample());
      end
      drain();
    end

    // ramp the integral up at full error, then pull it back down
    apply_setting(0, 1, 0, 0, UNITY_ALPHA, 32767);
    fast_mode = 1'b1;
    for (n = 0; n < SWEEP_ITEMS; n++) begin
      add_sample(-32768, 32767, 1'b0);
    end
    for (n = 0; n < UNWIND_ITEMS; n++) begin
      add_sample(32767, -32768, 1'b0);
    end
    drain();
    fast_mode = 1'b0;

    $display("Checked %0d results from %0d requests across %0d register settings.",
             results_seen, samples_taken, settings_applied);
    $display("Run spanned reset values, extreme angles and gains, zero limit, %s",
             "alpha off unity both ways, and an integral ramp with readback.");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
